// ===== hdl/rits_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the tag store.
`default_nettype none

package rits_pkg;

  localparam int SETS_DEF        = 1024;
  localparam int MAX_WAYS_DEF    = 8;
  localparam int MAP_ENTRIES_DEF = 16384;

  localparam int OP_W     = 2;
  localparam int ADDR_W   = 14;
  localparam int RND_W    = 32;
  localparam int CFG_W    = 4;
  localparam int MOD_STEP = 4;

  localparam logic [CFG_W-1:0] WAYS_RESET = 4'd8;

  localparam logic [OP_W-1:0] OP_ACCESS = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd1;
  localparam logic [OP_W-1:0] OP_SWAP   = 2'd2;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLR,
    ST_A_IDX,
    ST_A_IDX_W,
    ST_A_SET,
    ST_A_SET_W,
    ST_A_CMP,
    ST_A_VIC_W,
    ST_S_IDXA,
    ST_S_IDXA_W,
    ST_S_IDXB,
    ST_S_IDXB_W,
    ST_S_WRA,
    ST_S_WRB
  } state_t;

  typedef enum logic [1:0] {
    MOD_ADDR_MAP,
    MOD_RND_MAP,
    MOD_ENTRY_SETS,
    MOD_RND_WAYS
  } mod_sel_t;

  typedef enum logic [2:0] {
    MAP_NONE,
    MAP_RD_REM,
    MAP_WR_A,
    MAP_WR_B,
    MAP_WR_ID
  } map_op_t;

  typedef enum logic [1:0] {
    ROW_NONE,
    ROW_RD_REM,
    ROW_WR_VIC,
    ROW_CLR
  } row_op_t;

  typedef struct packed {
    logic     load;
    logic     mod_start;
    mod_sel_t mod_sel;
    map_op_t  map_op;
    row_op_t  row_op;
    logic     lat_idx_a;
    logic     lat_idx_b;
    logic     lat_ent_a;
    logic     sweep;
    logic     emit;
    logic     emit_hit;
  } cmd_t;

  typedef struct packed {
    logic mod_done;
    logic sweep_last;
    logic hit;
  } sts_t;

endpackage

`default_nettype wire

// ===== hdl/rits_mod.sv =====
// Iterative remainder unit: power-of-two divisors by a mask, others four bits per cycle.
`default_nettype none

module rits_mod #(
  parameter int DIV_W = 21
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [rits_pkg::RND_W-1:0] dividend,
  input  wire logic [DIV_W-1:0]           divisor,
  output logic                            done,
  output logic [DIV_W-1:0]                rem
);

  localparam int STEPS = rits_pkg::RND_W / rits_pkg::MOD_STEP;
  localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

  logic                       busy_r;
  logic                       done_r;
  logic [CNT_W-1:0]           cnt_r;
  logic [rits_pkg::RND_W-1:0] dvd_r;
  logic [DIV_W-1:0]           rem_r;
  logic [DIV_W-1:0]           div_r;

  logic                       pow2;
  logic [DIV_W:0]             step_t;
  logic [DIV_W-1:0]           step_r;
  logic [rits_pkg::RND_W-1:0] step_d;

  assign pow2 = ((divisor & (divisor - 1'b1)) == '0);

  // Restoring remainder: the partial remainder stays below the divisor, so one
  // conditional subtract per dividend bit is enough.
  always_comb begin
    step_r = rem_r;
    step_d = dvd_r;
    step_t = '0;
    for (int k = 0; k < rits_pkg::MOD_STEP; k++) begin
      step_t = {step_r, step_d[rits_pkg::RND_W-1]};
      step_d = {step_d[rits_pkg::RND_W-2:0], 1'b0};
      if (step_t >= {1'b0, div_r}) begin
        step_t = step_t - {1'b0, div_r};
      end
      step_r = step_t[DIV_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= '0;
        if (pow2) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
        end
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      div_r <= divisor;
      dvd_r <= dividend;
      if (pow2) begin
        rem_r <= dividend[DIV_W-1:0] & (divisor - 1'b1);
      end else begin
        rem_r <= '0;
      end
    end else if (busy_r) begin
      rem_r <= step_r;
      dvd_r <= step_d;
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire

// ===== hdl/rits_dp.sv =====
// Datapath: operand registers, remap table, tag and valid arrays, remainder unit, result word.
`default_nettype none

module rits_dp #(
  parameter int SETS        = rits_pkg::SETS_DEF,
  parameter int MAX_WAYS    = rits_pkg::MAX_WAYS_DEF,
  parameter int MAP_ENTRIES = rits_pkg::MAP_ENTRIES_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire rits_pkg::cmd_t              cmd,
  output rits_pkg::sts_t                   sts,
  input  wire logic [rits_pkg::ADDR_W-1:0] in_line_address,
  input  wire logic [rits_pkg::RND_W-1:0]  in_random_value,
  input  wire logic                        cfg_we,
  input  wire logic [rits_pkg::CFG_W-1:0]  cfg_wdata,
  output logic                             out_valid,
  output logic                             out_hit
);

  localparam int ADDR_W  = rits_pkg::ADDR_W;
  localparam int RND_W   = rits_pkg::RND_W;
  localparam int CFG_W   = rits_pkg::CFG_W;
  localparam int MAP_IW  = $clog2(MAP_ENTRIES);
  localparam int SET_W   = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WCNT_W  = $clog2(MAX_WAYS + 1);
  localparam int CMP_W   = (WCNT_W > CFG_W) ? WCNT_W : CFG_W;
  localparam int DIV_MAX = (MAP_ENTRIES > SETS) ? MAP_ENTRIES : SETS;
  localparam int DIV_W   = $clog2(DIV_MAX + 1);
  localparam int CNT_W   = $clog2(DIV_MAX);

  // Operands and configuration.
  logic [ADDR_W-1:0] addr_r;
  logic [RND_W-1:0]  rnd_r;
  logic [CFG_W-1:0]  ways_r;
  logic [WCNT_W-1:0] ways_eff;
  logic [CMP_W-1:0]  ways_cmp;

  // Remainder unit.
  logic [RND_W-1:0]  mod_dvd;
  logic [DIV_W-1:0]  mod_dsr;
  logic              mod_done;
  logic [DIV_W-1:0]  mod_rem;

  // Remap table.
  logic [MAP_IW-1:0] map_mem [MAP_ENTRIES];
  logic [MAP_IW-1:0] map_q_r;
  logic [MAP_IW-1:0] idx_a_r;
  logic [MAP_IW-1:0] idx_b_r;
  logic [MAP_IW-1:0] ent_a_r;
  logic [MAP_IW-1:0] map_addr;
  logic [MAP_IW-1:0] map_wd;
  logic              map_we;
  logic              map_re;

  // Tag and valid arrays, one row per set.
  logic [MAX_WAYS-1:0]             v_mem [SETS];
  logic [MAX_WAYS-1:0][ADDR_W-1:0] t_mem [SETS];
  logic [MAX_WAYS-1:0]             vq_r;
  logic [MAX_WAYS-1:0][ADDR_W-1:0] tq_r;
  logic [MAX_WAYS-1:0]             v_wd;
  logic [MAX_WAYS-1:0][ADDR_W-1:0] t_wd;
  logic [SET_W-1:0]                set_r;
  logic [SET_W-1:0]                row_addr;
  logic                            v_we;
  logic                            t_we;
  logic                            row_re;
  logic [WAY_W-1:0]                victim;
  logic [MAX_WAYS-1:0]             match;

  // Clearing sweep.
  logic [CNT_W-1:0] cnt_r;
  logic             cnt_last;
  logic             cnt_in_map;
  logic             cnt_in_set;

  logic out_valid_r;
  logic out_hit_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      addr_r <= in_line_address;
      rnd_r  <= in_random_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ways_r <= rits_pkg::WAYS_RESET;
    end else if (cfg_we) begin
      ways_r <= cfg_wdata;
    end
  end

  // Zero ways acts as one; anything above the array width saturates.
  always_comb begin
    ways_cmp = CMP_W'(ways_r);
    if (ways_r == '0) begin
      ways_eff = WCNT_W'(1);
    end else if (ways_cmp > CMP_W'(MAX_WAYS)) begin
      ways_eff = WCNT_W'(MAX_WAYS);
    end else begin
      ways_eff = ways_cmp[WCNT_W-1:0];
    end
  end

  always_comb begin
    case (cmd.mod_sel)
      rits_pkg::MOD_ADDR_MAP: begin
        mod_dvd = {{(RND_W - ADDR_W){1'b0}}, addr_r};
        mod_dsr = DIV_W'(MAP_ENTRIES);
      end
      rits_pkg::MOD_RND_MAP: begin
        mod_dvd = rnd_r;
        mod_dsr = DIV_W'(MAP_ENTRIES);
      end
      rits_pkg::MOD_ENTRY_SETS: begin
        mod_dvd = {{(RND_W - MAP_IW){1'b0}}, map_q_r};
        mod_dsr = DIV_W'(SETS);
      end
      rits_pkg::MOD_RND_WAYS: begin
        mod_dvd = rnd_r;
        mod_dsr = {{(DIV_W - WCNT_W){1'b0}}, ways_eff};
      end
      default: begin
        mod_dvd = rnd_r;
        mod_dsr = DIV_W'(MAP_ENTRIES);
      end
    endcase
  end

  rits_mod #(
    .DIV_W(DIV_W)
  ) u_mod (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.mod_start),
    .dividend(mod_dvd),
    .divisor (mod_dsr),
    .done    (mod_done),
    .rem     (mod_rem)
  );

  always_ff @(posedge clk) begin
    if (cmd.lat_idx_a) begin
      idx_a_r <= mod_rem[MAP_IW-1:0];
    end
    if (cmd.lat_idx_b) begin
      idx_b_r <= mod_rem[MAP_IW-1:0];
    end
    if (cmd.lat_ent_a) begin
      ent_a_r <= map_q_r;
    end
    if (cmd.row_op == rits_pkg::ROW_RD_REM) begin
      set_r <= mod_rem[SET_W-1:0];
    end
  end

  // Sweep counter walks every set and every map entry once.
  assign cnt_last   = (cnt_r == CNT_W'(DIV_MAX - 1));
  assign cnt_in_map = ({1'b0, cnt_r} < (CNT_W + 1)'(MAP_ENTRIES));
  assign cnt_in_set = ({1'b0, cnt_r} < (CNT_W + 1)'(SETS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.sweep) begin
      cnt_r <= cnt_last ? '0 : cnt_r + 1'b1;
    end
  end

  always_comb begin
    map_addr = idx_a_r;
    map_wd   = map_q_r;
    map_we   = 1'b0;
    map_re   = 1'b0;
    case (cmd.map_op)
      rits_pkg::MAP_RD_REM: begin
        map_addr = mod_rem[MAP_IW-1:0];
        map_re   = 1'b1;
      end
      rits_pkg::MAP_WR_A: begin
        map_addr = idx_a_r;
        map_wd   = map_q_r;
        map_we   = 1'b1;
      end
      rits_pkg::MAP_WR_B: begin
        map_addr = idx_b_r;
        map_wd   = ent_a_r;
        map_we   = 1'b1;
      end
      rits_pkg::MAP_WR_ID: begin
        map_addr = cnt_r[MAP_IW-1:0];
        map_wd   = cnt_r[MAP_IW-1:0];
        map_we   = cnt_in_map;
      end
      default: begin
        map_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[map_addr] <= map_wd;
    end
    if (map_re) begin
      map_q_r <= map_mem[map_addr];
    end
  end

  assign victim = mod_rem[WAY_W-1:0];

  always_comb begin
    row_addr = set_r;
    row_re   = 1'b0;
    v_we     = 1'b0;
    t_we     = 1'b0;
    v_wd     = vq_r;
    t_wd     = tq_r;
    case (cmd.row_op)
      rits_pkg::ROW_RD_REM: begin
        row_addr = mod_rem[SET_W-1:0];
        row_re   = 1'b1;
      end
      rits_pkg::ROW_WR_VIC: begin
        row_addr     = set_r;
        v_wd[victim] = 1'b1;
        t_wd[victim] = addr_r;
        v_we         = 1'b1;
        t_we         = 1'b1;
      end
      rits_pkg::ROW_CLR: begin
        row_addr = cnt_r[SET_W-1:0];
        v_wd     = '0;
        v_we     = cnt_in_set;
      end
      default: begin
        row_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (v_we) begin
      v_mem[row_addr] <= v_wd;
    end
    if (t_we) begin
      t_mem[row_addr] <= t_wd;
    end
    if (row_re) begin
      vq_r <= v_mem[row_addr];
      tq_r <= t_mem[row_addr];
    end
  end

  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      match[w] = vq_r[w] && (tq_r[w] == addr_r) && (WCNT_W'(w) < ways_eff);
    end
  end

  assign sts.mod_done   = mod_done;
  assign sts.sweep_last = cnt_last;
  assign sts.hit        = |match;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    out_hit_r <= cmd.emit_hit;
  end

  assign out_valid = out_valid_r;
  assign out_hit   = out_hit_r;

endmodule

`default_nettype wire

// ===== hdl/rits_ctrl.sv =====
// Controller state machine that sequences lookups, installs, swaps and clearing sweeps.
`default_nettype none

module rits_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [rits_pkg::OP_W-1:0] op,
  output logic                           busy,
  output rits_pkg::cmd_t                 cmd,
  input  wire rits_pkg::sts_t            sts
);

  rits_pkg::state_t state_r;
  rits_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rits_pkg::ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != rits_pkg::ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    cmd.load      = 1'b0;
    cmd.mod_start = 1'b0;
    cmd.mod_sel   = rits_pkg::MOD_ADDR_MAP;
    cmd.map_op    = rits_pkg::MAP_NONE;
    cmd.row_op    = rits_pkg::ROW_NONE;
    cmd.lat_idx_a = 1'b0;
    cmd.lat_idx_b = 1'b0;
    cmd.lat_ent_a = 1'b0;
    cmd.sweep     = 1'b0;
    cmd.emit      = 1'b0;
    cmd.emit_hit  = 1'b0;
    case (state_r)
      // The sweep after reset gives no result word; the one for a clear does.
      rits_pkg::ST_INIT: begin
        cmd.map_op = rits_pkg::MAP_WR_ID;
        cmd.row_op = rits_pkg::ROW_CLR;
        cmd.sweep  = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = rits_pkg::ST_IDLE;
        end
      end
      rits_pkg::ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          case (op)
            rits_pkg::OP_ACCESS: state_nxt = rits_pkg::ST_A_IDX;
            rits_pkg::OP_CLEAR:  state_nxt = rits_pkg::ST_CLR;
            rits_pkg::OP_SWAP:   state_nxt = rits_pkg::ST_S_IDXA;
            default:             cmd.emit  = 1'b1;
          endcase
        end
      end
      rits_pkg::ST_CLR: begin
        cmd.map_op = rits_pkg::MAP_WR_ID;
        cmd.row_op = rits_pkg::ROW_CLR;
        cmd.sweep  = 1'b1;
        if (sts.sweep_last) begin
          cmd.emit  = 1'b1;
          state_nxt = rits_pkg::ST_IDLE;
        end
      end
      rits_pkg::ST_A_IDX: begin
        cmd.mod_start = 1'b1;
        cmd.mod_sel   = rits_pkg::MOD_ADDR_MAP;
        state_nxt     = rits_pkg::ST_A_IDX_W;
      end
      rits_pkg::ST_A_IDX_W: begin
        if (sts.mod_done) begin
          cmd.map_op = rits_pkg::MAP_RD_REM;
          state_nxt  = rits_pkg::ST_A_SET;
        end
      end
      rits_pkg::ST_A_SET: begin
        cmd.mod_start = 1'b1;
        cmd.mod_sel   = rits_pkg::MOD_ENTRY_SETS;
        state_nxt     = rits_pkg::ST_A_SET_W;
      end
      rits_pkg::ST_A_SET_W: begin
        if (sts.mod_done) begin
          cmd.row_op = rits_pkg::ROW_RD_REM;
          state_nxt  = rits_pkg::ST_A_CMP;
        end
      end
      rits_pkg::ST_A_CMP: begin
        if (sts.hit) begin
          cmd.emit     = 1'b1;
          cmd.emit_hit = 1'b1;
          state_nxt    = rits_pkg::ST_IDLE;
        end else begin
          cmd.mod_start = 1'b1;
          cmd.mod_sel   = rits_pkg::MOD_RND_WAYS;
          state_nxt     = rits_pkg::ST_A_VIC_W;
        end
      end
      rits_pkg::ST_A_VIC_W: begin
        if (sts.mod_done) begin
          cmd.row_op = rits_pkg::ROW_WR_VIC;
          cmd.emit   = 1'b1;
          state_nxt  = rits_pkg::ST_IDLE;
        end
      end
      rits_pkg::ST_S_IDXA: begin
        cmd.mod_start = 1'b1;
        cmd.mod_sel   = rits_pkg::MOD_ADDR_MAP;
        state_nxt     = rits_pkg::ST_S_IDXA_W;
      end
      rits_pkg::ST_S_IDXA_W: begin
        if (sts.mod_done) begin
          cmd.lat_idx_a = 1'b1;
          cmd.map_op    = rits_pkg::MAP_RD_REM;
          state_nxt     = rits_pkg::ST_S_IDXB;
        end
      end
      rits_pkg::ST_S_IDXB: begin
        cmd.mod_start = 1'b1;
        cmd.mod_sel   = rits_pkg::MOD_RND_MAP;
        cmd.lat_ent_a = 1'b1;
        state_nxt     = rits_pkg::ST_S_IDXB_W;
      end
      rits_pkg::ST_S_IDXB_W: begin
        if (sts.mod_done) begin
          cmd.lat_idx_b = 1'b1;
          cmd.map_op    = rits_pkg::MAP_RD_REM;
          state_nxt     = rits_pkg::ST_S_WRA;
        end
      end
      rits_pkg::ST_S_WRA: begin
        cmd.map_op = rits_pkg::MAP_WR_A;
        state_nxt  = rits_pkg::ST_S_WRB;
      end
      rits_pkg::ST_S_WRB: begin
        cmd.map_op = rits_pkg::MAP_WR_B;
        cmd.emit   = 1'b1;
        state_nxt  = rits_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = rits_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/randomized_index_cache_tag_store_top.sv =====
// Access: remap-table index, table read, set index, set read, compare; a miss then picks a victim.
// Swap: two table indices and reads, then two writes; clear: a pass over all sets and entries.
// An unused code emits a result word from idle. Non-power-of-two remainders take 4 bits per cycle.
// The single-port remap table and set array are read then written in turn; start is taken in idle.
// After reset busy stays high for a clearing pass over every set and map entry.
// The receiver cannot stall: every result word is shown for exactly one cycle.
`default_nettype none

module randomized_index_cache_tag_store_top #(
  parameter int SETS        = rits_pkg::SETS_DEF,
  parameter int MAX_WAYS    = rits_pkg::MAX_WAYS_DEF,
  parameter int MAP_ENTRIES = rits_pkg::MAP_ENTRIES_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [rits_pkg::OP_W-1:0]   in_operation,
  input  wire logic [rits_pkg::ADDR_W-1:0] in_line_address,
  input  wire logic [rits_pkg::RND_W-1:0]  in_random_value,
  input  wire logic                        cfg_we,
  input  wire logic [rits_pkg::CFG_W-1:0]  cfg_wdata,
  output logic                             out_valid,
  output logic                             out_hit
);

  rits_pkg::cmd_t cmd;
  rits_pkg::sts_t sts;

  rits_ctrl u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .op   (in_operation),
    .busy (busy),
    .cmd  (cmd),
    .sts  (sts)
  );

  rits_dp #(
    .SETS       (SETS),
    .MAX_WAYS   (MAX_WAYS),
    .MAP_ENTRIES(MAP_ENTRIES)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_line_address(in_line_address),
    .in_random_value(in_random_value),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .out_valid      (out_valid),
    .out_hit        (out_hit)
  );

endmodule

`default_nettype wire
